// ----- rtl/core/frts_pkg.sv -----
// ----------------------------------------------------------------------------
// frts_pkg
// Types and constants shared by the fractional-rate task scheduler files.
// ----------------------------------------------------------------------------
package frts_pkg;

	// Request modes.
	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_DROP = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_DROP  = 2'd1;
	localparam logic [1:0] KIND_FIRED = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Q16.16 constants.
	localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
	localparam logic [31:0] ZERO_Q16 = 32'h0000_0000;
	localparam logic [31:0] SAT_Q16  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0]  task_id;
		logic [31:0] rate;
		logic [31:0] phase;
		logic [31:0] last_time;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_TICK
	} state_t;

endpackage

// ----- rtl/core/frts_ram.sv -----
// ----------------------------------------------------------------------------
// frts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module frts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic [ADDR_W-1:0]         raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/fractional_rate_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// fractional_rate_task_scheduler
// Table of periodic tasks with Q16.16 rates and saturating phase accumulators.
// ----------------------------------------------------------------------------
// All entries live in one memory with a registered read, and every add, drop
// and tick walks it one entry per clock through that single read port, so the
// cost of a request grows with the number of valid entries N. An add searches
// for the id, a drop is a search that stops at the match and then a compaction
// over the entries behind it, and a tick passes each entry through its read,
// subtract, multiply and accumulate stages. busy is high for the whole
// request; results appear as one-cycle pulses on result_valid and must be
// taken in that cycle, since the receiver has no way to stall the block. A
// tick gives one result per firing task, in table order, with last_of_run on
// the final one; a tick with no firing gives nothing, and an unused mode is
// accepted and dropped silently.
module fractional_rate_task_scheduler
	import frts_pkg::*;
#(
	parameter int NUM_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  task_id,
	input  logic signed [31:0] task_rate,
	input  logic [31:0] now_time,
	output logic        result_valid,
	output logic [1:0]  result_kind,
	output logic [7:0]  fired_id,
	output logic [1:0]  status,
	output logic        last_of_run
);
	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	state_t state_q, state_d;

	// Latched request.
	logic [1:0]  mode_q;
	logic [7:0]  id_q;
	logic [31:0] rate_q;
	logic [31:0] now_q;

	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
	logic             issue;

	// Memory ports.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;

	// Read stage.
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;

	// Tick stages.
	logic             v_s2, v_s3;
	logic [31:0]      delta_s2;
	logic [31:0]      rate_s2, rate_s3;
	logic [31:0]      phase_s2, phase_s3;
	logic [7:0]       id_s2, id_s3;
	logic [IDX_W-1:0] idx_s2, idx_s3;
	logic [63:0]      prod_s3;

	// Held firing, released once it is known whether another follows.
	logic       pend_v_q;
	logic [7:0] pend_id_q;
	logic       pend_set, pend_clr;

	// Result load.
	logic       res_load;
	logic [1:0] res_kind, res_status;
	logic [7:0] res_id;
	logic       res_last;

	logic        hit;
	logic [48:0] acc_sum;
	logic [31:0] acc_sat;
	logic [31:0] new_phase;
	logic        fire_s3;
	logic        accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign hit    = v_s1 && (ram_rdata.task_id == id_q);

	frts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Accumulate: the Q32.32 product is truncated to Q16.16 and added with
	// saturation; a negative rate fires without touching the phase.
	always_comb begin
		acc_sum = {17'd0, phase_s3} + {1'b0, prod_s3[63:16]};
		acc_sat = (acc_sum[48:32] != 17'd0) ? SAT_Q16 : acc_sum[31:0];
		if (rate_s3[31]) begin
			fire_s3   = 1'b1;
			new_phase = phase_s3;
		end else if (acc_sat >= ONE_Q16) begin
			fire_s3   = 1'b1;
			new_phase = ZERO_Q16;
		end else begin
			fire_s3   = 1'b0;
			new_phase = acc_sat;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_idx_d   = rd_idx_q;
		count_d    = count_q;
		issue      = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = idx_s1;
		ram_wdata  = ram_rdata;
		pend_set   = 1'b0;
		pend_clr   = 1'b0;
		res_load   = 1'b0;
		res_kind   = mode_q;
		res_id     = id_q;
		res_status = ST_DONE;
		res_last   = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				rd_idx_d = '0;
				if (start) begin
					unique case (mode)
						MODE_ADD, MODE_DROP: state_d = ST_SEARCH;
						MODE_TICK:           state_d = ST_TICK;
						default:             state_d = ST_IDLE;
					endcase
				end
			end

			ST_SEARCH: begin
				if (hit) begin
					if (mode_q == MODE_ADD) begin
						ram_we    = 1'b1;
						ram_waddr = idx_s1;
						ram_wdata = '{task_id: id_q, rate: rate_q, phase: ZERO_Q16,
							last_time: now_q};
						res_load  = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						rd_idx_d = CNT_W'(idx_s1) + CNT_ONE;
						state_d  = ST_SHIFT;
					end
				end else if ((rd_idx_q >= count_q) && !v_s1) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
					if (mode_q == MODE_ADD) begin
						if (count_q < CNT_MAX) begin
							ram_we    = 1'b1;
							ram_waddr = count_q[IDX_W-1:0];
							ram_wdata = '{task_id: id_q, rate: rate_q, phase: ZERO_Q16,
								last_time: now_q};
							count_d   = count_q + CNT_ONE;
						end else begin
							res_status = ST_FULL;
						end
					end else begin
						res_status = ST_NOT_FOUND;
					end
				end else if (rd_idx_q < count_q) begin
					issue    = 1'b1;
					rd_idx_d = rd_idx_q + CNT_ONE;
				end
			end

			ST_SHIFT: begin
				// Each entry read here is written one place lower.
				if (v_s1) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1 - IDX_W'(1);
					ram_wdata = ram_rdata;
				end
				if (rd_idx_q < count_q) begin
					issue    = 1'b1;
					rd_idx_d = rd_idx_q + CNT_ONE;
				end else if (!v_s1) begin
					count_d  = count_q - CNT_ONE;
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			ST_TICK: begin
				if (rd_idx_q < count_q) begin
					issue    = 1'b1;
					rd_idx_d = rd_idx_q + CNT_ONE;
				end
				if (v_s3) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s3;
					ram_wdata = '{task_id: id_s3, rate: rate_s3, phase: new_phase,
						last_time: now_q};
					if (fire_s3) begin
						pend_set = 1'b1;
						if (pend_v_q) begin
							res_load = 1'b1;
							res_kind = KIND_FIRED;
							res_id   = pend_id_q;
							res_last = 1'b0;
						end
					end
				end else if ((rd_idx_q >= count_q) && !v_s1 && !v_s2) begin
					state_d = ST_IDLE;
					if (pend_v_q) begin
						pend_clr = 1'b1;
						res_load = 1'b1;
						res_kind = KIND_FIRED;
						res_id   = pend_id_q;
					end
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			pend_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			rd_idx_q     <= rd_idx_d;
			v_s1         <= issue;
			v_s2         <= v_s1 && (state_q == ST_TICK);
			v_s3         <= v_s2;
			result_valid <= res_load;
			if (pend_set) begin
				pend_v_q <= 1'b1;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			id_q   <= task_id;
			rate_q <= task_rate;
			now_q  <= now_time;
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];

		delta_s2 <= now_q - ram_rdata.last_time;
		rate_s2  <= ram_rdata.rate;
		phase_s2 <= ram_rdata.phase;
		id_s2    <= ram_rdata.task_id;
		idx_s2   <= idx_s1;

		prod_s3  <= 64'(delta_s2) * 64'(rate_s2);
		rate_s3  <= rate_s2;
		phase_s3 <= phase_s2;
		id_s3    <= id_s2;
		idx_s3   <= idx_s2;

		if (pend_set) begin
			pend_id_q <= id_s3;
		end
		if (res_load) begin
			result_kind <= res_kind;
			fired_id    <= res_id;
			status      <= res_status;
			last_of_run <= res_last;
		end
	end

endmodule

// ----- rtl/core/frts_checker.sv -----
// ----------------------------------------------------------------------------
// frts_port_checker
// Port-level checks for the fractional-rate task scheduler, bound to the top.
// ----------------------------------------------------------------------------
module frts_port_checker
	import frts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       result_valid,
	input logic [1:0] result_kind,
	input logic [1:0] status,
	input logic       last_of_run
);

	// An add or drop request always raises busy once it is accepted.
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_ADD || mode == MODE_DROP)) |=> busy)
		else $error("add or drop request did not raise busy");

	// Add and drop each answer with a single result.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_kind == KIND_ADD || result_kind == KIND_DROP))
			|-> last_of_run)
		else $error("add or drop status not marked last");

	// A firing never carries an error status.
	a_fire_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_FIRED) |-> (status == ST_DONE))
		else $error("fired result with nonzero status");

	// The final result of a request shows the block already free.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |-> !busy)
		else $error("busy still high on final result");

endmodule

bind fractional_rate_task_scheduler frts_port_checker u_frts_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.mode        (mode),
	.result_valid(result_valid),
	.result_kind (result_kind),
	.status      (status),
	.last_of_run (last_of_run)
);

// ----- verif/frts_checker.sv -----
// ----------------------------------------------------------------------------
// frts_checker
// Watches the request and result ports of the task scheduler. It keeps its own
// copy of the task table, works out the results of every accepted request,
// and compares each result pulse against the oldest one still due.
// ----------------------------------------------------------------------------
module frts_checker
	import frts_pkg::*;
#(
	parameter int NUM_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  task_id,
	input  logic [31:0] task_rate,
	input  logic [31:0] now_time,
	input  logic        result_valid,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  fired_id,
	input  logic [1:0]  status,
	input  logic        last_of_run,
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] id;
		logic [1:0] st;
		logic       last;
	} outcome_t;

	entry_t   task_tbl [NUM_ENTRIES];
	int       live_cnt;
	int       errs;
	outcome_t due_q [$];

	function automatic int find_task(logic [7:0] id);
		for (int i = 0; i < live_cnt; i++)
			if (task_tbl[i].task_id == id)
				return i;
		return -1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int         pos;
		int         n_prior;
		logic       fire;
		logic [31:0] delta;
		logic [63:0] prod;
		logic [63:0] sum;
		outcome_t   got;
		outcome_t   want;
		if (!arst_n) begin
			live_cnt = 0;
			errs = 0;
			due_q.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// Results always belong to requests accepted earlier, so they are
			// checked before this edge's request adds its own expectations.
			if (result_valid) begin
				got = '{result_kind, fired_id, status, last_of_run};
				if (due_q.size() == 0) begin
					$error("result with nothing due: kind %0d id %0d status %0d last %0d",
						got.kind, got.id, got.st, got.last);
					errs++;
				end else begin
					want = due_q.pop_front();
					if (got.kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, got.kind);
						errs++;
					end
					if (got.id !== want.id) begin
						$error("fired_id: expected %0d, got %0d", want.id, got.id);
						errs++;
					end
					if (got.st !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, got.st);
						errs++;
					end
					if (got.last !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, got.last);
						errs++;
					end
				end
			end

			if (start && !busy) begin
				case (mode)
					MODE_ADD: begin
						pos = find_task(task_id);
						if (pos < 0 && live_cnt < NUM_ENTRIES) begin
							pos = live_cnt;
							task_tbl[pos].task_id = task_id;
							live_cnt++;
						end
						if (pos >= 0) begin
							task_tbl[pos].rate = task_rate;
							task_tbl[pos].phase = ZERO_Q16;
							task_tbl[pos].last_time = now_time;
							due_q.push_back('{KIND_ADD, task_id, ST_DONE, 1'b1});
						end else begin
							due_q.push_back('{KIND_ADD, task_id, ST_FULL, 1'b1});
						end
					end
					MODE_DROP: begin
						pos = find_task(task_id);
						if (pos >= 0) begin
							for (int j = pos; j < live_cnt - 1; j++)
								task_tbl[j] = task_tbl[j + 1];
							live_cnt--;
							due_q.push_back('{KIND_DROP, task_id, ST_DONE, 1'b1});
						end else begin
							due_q.push_back('{KIND_DROP, task_id, ST_NOT_FOUND, 1'b1});
						end
					end
					MODE_TICK: begin
						n_prior = due_q.size();
						for (int i = 0; i < live_cnt; i++) begin
							delta = now_time - task_tbl[i].last_time;
							task_tbl[i].last_time = now_time;
							fire = 1'b0;
							if (task_tbl[i].rate[31]) begin
								fire = 1'b1;
							end else begin
								// Q16.16 times Q16.16 is Q32.32; keep Q16.16 and saturate.
								prod = 64'(delta) * 64'(task_tbl[i].rate);
								sum = 64'(task_tbl[i].phase) + (prod >> 16);
								task_tbl[i].phase = (sum > 64'(SAT_Q16)) ? SAT_Q16 : sum[31:0];
								if (task_tbl[i].phase >= ONE_Q16) begin
									fire = 1'b1;
									task_tbl[i].phase = ZERO_Q16;
								end
							end
							if (fire)
								due_q.push_back('{KIND_FIRED, task_tbl[i].task_id, ST_DONE, 1'b0});
						end
						if (due_q.size() > n_prior) begin
							want = due_q.pop_back();
							want.last = 1'b1;
							due_q.push_back(want);
						end
					end
					default: begin
						// The unused mode is swallowed without a result.
					end
				endcase
			end

			outstanding <= due_q.size();
			fail_count <= errs;
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives add, drop, tick and unused-mode requests into the task scheduler with
// random gaps, first a directed set of corner cases and then random traffic
// around a small pool of task ids, and leaves all checking to frts_checker.
// ----------------------------------------------------------------------------
module tb
	import frts_pkg::*;
();

	localparam int         NUM_ENTRIES  = 16;
	localparam int         RANDOM_ITEMS = 210;
	localparam int         IDLE_LIMIT   = 3000;
	localparam int         SETTLE       = 60;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [7:0]  task_id;
	logic [31:0] task_rate;
	logic [31:0] now_time;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [7:0]  fired_id;
	logic [1:0]  status;
	logic        last_of_run;

	int          fail_count;
	int          outstanding;
	int          idle_cycles = 0;
	int          results_seen = 0;
	int          mode_cnt [4];
	logic [31:0] now_q;
	logic [7:0]  id_pool [20];
	logic        no_gap_run;

	fractional_rate_task_scheduler #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.task_id(task_id),
		.task_rate(task_rate),
		.now_time(now_time),
		.result_valid(result_valid),
		.result_kind(result_kind),
		.fired_id(fired_id),
		.status(status),
		.last_of_run(last_of_run)
	);

	frts_checker #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.task_id(task_id),
		.task_rate(task_rate),
		.now_time(now_time),
		.result_valid(result_valid),
		.result_kind(result_kind),
		.fired_id(fired_id),
		.status(status),
		.last_of_run(last_of_run),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any accepted request or result pulse counts as progress.
	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || result_valid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (result_valid)
			results_seen <= results_seen + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Waits a random gap, then holds the request until busy is low at an edge.
	// start stays high across back-to-back requests.
	task automatic send_request(logic [1:0] m, logic [7:0] id, logic [31:0] rate,
			logic [31:0] t);
		int gap;
		if (no_gap_run)
			gap = 0;
		else
			gap = $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		task_id <= id;
		task_rate <= rate;
		now_time <= t;
		do
			@(posedge clk);
		while (busy);
		mode_cnt[m]++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0 || busy);
	endtask

	function automatic logic [31:0] draw_rate();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 4)
			return $urandom_range(0, 32'h0003_0000);
		else if (pick <= 6)
			return {1'b1, 31'($urandom)};
		else if (pick == 7)
			return $urandom;
		else if (pick == 8)
			return ZERO_Q16;
		else
			return 32'h7FFF_0000 | 32'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic [7:0] draw_id();
		if ($urandom_range(0, 99) < 85)
			return id_pool[$urandom_range(0, 19)];
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [1:0] m;
		int         pick;
		clk_init: begin
			arst_n = 1'b0;
			start = 1'b0;
			mode = MODE_ADD;
			task_id = '0;
			task_rate = '0;
			now_time = '0;
			no_gap_run = 1'b0;
			foreach (mode_cnt[i])
				mode_cnt[i] = 0;
		end
		id_pool[0] = 8'd0;
		id_pool[1] = 8'd255;
		for (int i = 2; i < 20; i++)
			id_pool[i] = 8'($urandom_range(1, 254));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corner cases on an empty and then a small table.
		send_request(MODE_TICK, 8'd9, $urandom, 32'h0000_0000);
		send_request(MODE_DROP, 8'd7, $urandom, 32'h0000_0000);
		send_request(MODE_ADD, 8'd0, ONE_Q16, 32'h0000_0000);
		send_request(MODE_ADD, 8'd255, 32'h8000_0000, 32'h0000_0000);
		send_request(MODE_ADD, 8'd1, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(MODE_ADD, 8'd2, ZERO_Q16, 32'h0000_0000);
		// Exactly one second at rate 1.0 reaches the firing threshold.
		send_request(MODE_TICK, 8'd0, 32'h0, 32'h0001_0000);
		// Time goes backwards, so the elapsed time wraps around.
		send_request(MODE_TICK, 8'd0, 32'h0, 32'h0000_8000);
		send_request(MODE_ADD, 8'd0, 32'h0000_8000, 32'h0000_8000);
		send_request(MODE_TICK, 8'd0, 32'h0, 32'h0001_8000);
		send_request(MODE_TICK, 8'd0, 32'h0, 32'h0002_8000);
		send_request(MODE_UNUSED, 8'($urandom), $urandom, $urandom);
		send_request(MODE_DROP, 8'd255, 32'h0, 32'h0002_8000);
		send_request(MODE_DROP, 8'd255, 32'h0, 32'h0002_8000);
		send_request(MODE_ADD, 8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(MODE_ADD, 8'd4, 32'h0000_0001, 32'hFFFF_0000);
		send_request(MODE_TICK, 8'd0, 32'h0, 32'h0000_0000);
		send_request(MODE_TICK, 8'd0, 32'h0, 32'hFFFF_FFFF);
		send_request(MODE_DROP, 8'd0, 32'h0, 32'hFFFF_FFFF);
		send_request(MODE_DROP, 8'd4, 32'h0, 32'hFFFF_FFFF);
		send_request(MODE_TICK, 8'd0, 32'h0, 32'h0000_4000);
		now_q = 32'h0000_4000;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 14) == 0)
				no_gap_run = ~no_gap_run;
			if ($urandom_range(0, 19) == 0)
				now_q = $urandom;
			else
				now_q = now_q + $urandom_range(0, 32'h0002_0000);

			if (n == RANDOM_ITEMS / 2)
				wait_drained();

			if (n >= 60 && n < 80) begin
				// Burst of fresh ids that fills the table and runs into full.
				send_request(MODE_ADD, 8'd100 + 8'(n - 60), draw_rate(), now_q);
			end else begin
				pick = $urandom_range(0, 19);
				if (pick <= 7)
					m = MODE_ADD;
				else if (pick <= 11)
					m = MODE_DROP;
				else if (pick <= 18)
					m = MODE_TICK;
				else
					m = MODE_UNUSED;
				send_request(m, draw_id(), draw_rate(), now_q);
			end
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);

		if (outstanding != 0)
			$error("%0d expected results never arrived", outstanding);
		$display("Covered %0d adds, %0d drops, %0d ticks, %0d unused-mode requests;",
			mode_cnt[MODE_ADD], mode_cnt[MODE_DROP], mode_cnt[MODE_TICK],
			mode_cnt[MODE_UNUSED]);
		$display("%0d result pulses were checked against the table model.", results_seen);
		if (fail_count == 0 && outstanding == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/frts_pkg.sv
rtl/core/frts_ram.sv
rtl/core/fractional_rate_task_scheduler.sv
rtl/core/frts_checker.sv
verif/frts_checker.sv
verif/tb.sv
